>>> sv/btda_pkg.sv
package btda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int CONV_BITS   = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 6;
    localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(CONV_BITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DEC_MAX    = 4'd9;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } cell_ctrl_t;

endpackage

>>> sv/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter.
// Input channel: in_valid/in_ready with a 32-bit unsigned value per beat.
// Output channel: out_valid/out_ready with one ASCII digit per beat
// (digit_char, '0'..'9'), most significant first, no leading zeros;
// last is high on the final digit. Zero gives the single beat '0'.
// A row of ten BCD digit cells runs shift-add-3 over all 32 input bits,
// then leading zero digits are shifted out at one per cycle, then digits
// are shifted to the output register at one per cycle while the receiver
// takes them. One item is worked on at a time; in_ready is high only
// when idle, which is reached as soon as the last digit sits in the
// output register. When the receiver stalls, the output register holds
// its beat and the cell row waits. Reset empties the output register
// and returns to idle.
module binary_to_decimal_ascii_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [btda_pkg::FIELD_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [btda_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                                state_reg;
    logic [btda_pkg::CONV_BITS-1:0]        bin_reg;
    logic [btda_pkg::BIT_CNT_W-1:0]        bit_cnt_reg;
    logic [btda_pkg::CNT_W-1:0]            cnt_reg;
    logic                                  out_valid_reg;
    logic [btda_pkg::CHAR_W-1:0]           digit_char_reg;
    logic                                  last_reg;

    logic [btda_pkg::DIGIT_W-1:0]          digit [btda_pkg::NUM_DIGITS];
    logic                                  carry [btda_pkg::NUM_DIGITS+1];
    logic [btda_pkg::DIGIT_W-1:0]          top_digit;
    btda_pkg::cell_ctrl_t                  ctrl;
    logic                                  in_fire;
    logic                                  load_out;
    logic                                  skip_move;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign top_digit = digit[btda_pkg::NUM_DIGITS-1];
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign skip_move = (state_reg == ST_SKIP) && (top_digit == '0)
                       && (cnt_reg > btda_pkg::CNT_W'(1));

    assign ctrl.clear  = in_fire;
    assign ctrl.dabble = (state_reg == ST_CONV);
    assign ctrl.move   = skip_move || load_out;

    assign carry[0] = bin_reg[btda_pkg::CONV_BITS-1];

    genvar i;
    generate
        for (i = 0; i < btda_pkg::NUM_DIGITS; i++)
        begin : g_cell
            btda_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .cin   (carry[i]),
                .din   ((i == 0) ? {btda_pkg::DIGIT_W{1'b0}} : digit[(i == 0) ? 0 : i-1]),
                .digit (digit[i]),
                .cout  (carry[i+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bin_reg        <= '0;
            bit_cnt_reg    <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            digit_char_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        bin_reg     <= value[btda_pkg::CONV_BITS-1:0];
                        bit_cnt_reg <= btda_pkg::BIT_CNT_W'(btda_pkg::CONV_BITS);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bin_reg     <= bin_reg << 1;
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == btda_pkg::BIT_CNT_W'(1))
                    begin
                        cnt_reg   <= btda_pkg::CNT_W'(btda_pkg::NUM_DIGITS);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    if (skip_move)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        digit_char_reg <= btda_pkg::ASCII_ZERO
                                          + {{(btda_pkg::CHAR_W-btda_pkg::DIGIT_W){1'b0}},
                                             top_digit};
                        last_reg       <= (cnt_reg == btda_pkg::CNT_W'(1));
                        cnt_reg        <= cnt_reg - 1'b1;
                        if (cnt_reg == btda_pkg::CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;

`ifndef NO_ASSERTIONS
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_char_reg >= btda_pkg::ASCII_ZERO)
                       && (digit_char_reg <= btda_pkg::ASCII_ZERO + 6'd9))
        else $error("digit_char outside '0'..'9'");

    a_top_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (top_digit <= btda_pkg::DEC_MAX))
        else $error("converted digit is not decimal");

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT)
            |-> (cnt_reg != '0) && (cnt_reg <= btda_pkg::CNT_W'(btda_pkg::NUM_DIGITS)))
        else $error("digit count out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && cnt_reg == btda_pkg::CNT_W'(1)) |=> (state_reg == ST_IDLE) && last_reg)
        else $error("final digit did not end the item");

    a_first_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP && !skip_move) |-> (top_digit != '0)
                                              || (cnt_reg == btda_pkg::CNT_W'(1)))
        else $error("leading zero left in front");
`endif

endmodule

>>> sv/btda_cell.sv
module btda_cell (
    input  logic                           clk,
    input  btda_pkg::cell_ctrl_t           ctrl,
    input  logic                           cin,
    input  logic [btda_pkg::DIGIT_W-1:0]   din,
    output logic [btda_pkg::DIGIT_W-1:0]   digit,
    output logic                           cout
);

    logic [btda_pkg::DIGIT_W-1:0] digit_reg;
    logic [btda_pkg::DIGIT_W-1:0] digit_next;
    logic [btda_pkg::DIGIT_W-1:0] adj;

    // add-3 before the shift keeps the digit decimal after doubling
    always_comb
    begin
        if (digit_reg >= btda_pkg::ADJ_LIMIT)
        begin
            adj = digit_reg + btda_pkg::ADJ_ADD;
        end
        else
        begin
            adj = digit_reg;
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[btda_pkg::DIGIT_W-2:0], cin};
        end
        else if (ctrl.move)
        begin
            digit_next = din;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;
    assign cout  = adj[btda_pkg::DIGIT_W-1];

endmodule
